[src/rfcg_pkg.sv]
`default_nettype none

package rfcg_pkg;

   // window datapath width
   localparam int WINDOW_WIDTH = 20;

   localparam int OP_W    = 2;
   localparam int TIME_W  = 32;
   localparam int ACKED_W = 16;
   localparam int ACC_W   = 32;
   localparam int EST_W   = 32;
   localparam int CNT_W   = 27;
   localparam int THR_W   = 20;
   localparam int BETA_W  = 10;
   localparam int GAIN_W  = 13;
   localparam int HOLD_W  = 10;

   // (window * gain) >> 3
   localparam int STEP_W = WINDOW_WIDTH + GAIN_W - 3;

   localparam int DIV_W      = 32;
   localparam int DIV_ITER_W = $clog2(DIV_W + 1);

   localparam logic [OP_W-1:0] OP_ACK        = 2'd0;
   localparam logic [OP_W-1:0] OP_LOSS_REQ   = 2'd1;
   localparam logic [OP_W-1:0] OP_TX_START   = 2'd2;
   localparam logic [OP_W-1:0] OP_LOSS_STATE = 2'd3;

   typedef struct packed {
      logic                  start;
      logic [DIV_ITER_W-1:0] iterations;
      logic [DIV_W-1:0]      dividend;
      logic [DIV_W-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

[src/reno_friendly_cwnd_growth_top.sv]
`default_nettype none

// Sequencing: an ack with recomputation runs up to two passes of the shared
//   divider plus sequencer steps; an ack inside the hold interval, a loss request,
//   loss state and transmit start run through sequencer steps only.
// Throughput: one item at a time; req_stall is high from acceptance until the result
//   beat is loaded into the output register.
// Reset (synchronous, active high): registers to 717/15/31, all flow state to zero.
module reno_friendly_cwnd_growth_top (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [rfcg_pkg::OP_W-1:0]             req_opcode,
   input  wire  [rfcg_pkg::TIME_W-1:0]           req_now_ticks,
   input  wire  [rfcg_pkg::WINDOW_WIDTH-1:0]     req_window,
   input  wire  [rfcg_pkg::ACKED_W-1:0]          req_acked_count,
   input  wire  [rfcg_pkg::TIME_W-1:0]           req_last_send_ticks,
   // response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [rfcg_pkg::CNT_W-1:0]            rsp_acks_per_increment,
   output logic [rfcg_pkg::THR_W-1:0]            rsp_slow_start_threshold,
   // register port
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [3:0]                            csr_paddr,
   input  wire  [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import rfcg_pkg::*;

   localparam logic [1:0] CSR_BACKOFF = 2'd0;
   localparam logic [1:0] CSR_GAIN    = 2'd1;
   localparam logic [1:0] CSR_HOLD    = 2'd2;

   localparam int PROD_W = WINDOW_WIDTH + GAIN_W;
   localparam int THRP_W = WINDOW_WIDTH + BETA_W;
   localparam int CMP_W  = (STEP_W > ACC_W) ? STEP_W : ACC_W;

   // sequencer
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ACK   = 4'd1;  // accumulate, hold check, step
   localparam logic [3:0] S_CHK   = 4'd2;  // launch accumulator / step division
   localparam logic [3:0] S_DIV1  = 4'd3;
   localparam logic [3:0] S_EST   = 4'd4;  // launch window / excess division
   localparam logic [3:0] S_DIV2  = 4'd5;
   localparam logic [3:0] S_LOSS  = 4'd6;
   localparam logic [3:0] S_TX1   = 4'd7;  // epoch += idle
   localparam logic [3:0] S_TX2   = 4'd8;  // clamp epoch to now
   localparam logic [3:0] S_CLEAR = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [3:0] state_ff, state_in;

   // registers
   logic [BETA_W-1:0] beta_ff, beta_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;

   // flow state
   logic [CNT_W-1:0]        inc_ff, inc_in;
   logic [WINDOW_WIDTH-1:0] prev_max_ff, prev_max_in;
   logic [WINDOW_WIDTH-1:0] prev_win_ff, prev_win_in;
   logic [TIME_W-1:0]       prev_time_ff, prev_time_in;
   logic [TIME_W-1:0]       epoch_ff, epoch_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [EST_W-1:0]        est_ff, est_in;
   logic                    tx_flag_ff, tx_flag_in;

   // captured request beat and working values
   logic [OP_W-1:0]         op_ff, op_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [WINDOW_WIDTH-1:0] win_ff, win_in;
   logic [ACKED_W-1:0]      acked_ff, acked_in;
   logic [TIME_W-1:0]       lsend_ff, lsend_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [THR_W-1:0]        thr_ff, thr_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [THR_W-1:0] rsp_thr_ff, rsp_thr_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   rfcg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // datapath terms
   logic [TIME_W-1:0]       since;
   logic                    hold_skip;
   logic [ACC_W-1:0]        acc_sum;
   logic [WINDOW_WIDTH-1:0] win_nz;
   logic [PROD_W-1:0]       step_prod;
   logic [STEP_W-1:0]       step_raw;
   logic [THRP_W-1:0]       thr_prod;
   logic [WINDOW_WIDTH-1:0] thr_raw;
   logic [WINDOW_WIDTH-1:0] thr_val;
   logic [DIV_W-1:0]        thr_ext;
   logic [EST_W-1:0]        win_ext;
   logic [63:0]             win100;
   logic [DIV_W-1:0]        q_clamped;
   logic [TIME_W-1:0]       idle_ticks;
   logic [TIME_W-1:0]       since_epoch;
   logic                    cfg_write;

   always_comb begin
      since      = now_ff - prev_time_ff;
      // negative time since update counts as inside the hold interval
      hold_skip  = (prev_win_ff == win_ff) &&
                   (since[TIME_W-1] || (since <= TIME_W'(hold_ff)));
      acc_sum    = acc_ff + ACC_W'(acked_ff);
      win_nz     = (win_ff == '0) ? WINDOW_WIDTH'(1) : win_ff;
      step_prod  = PROD_W'(win_nz) * PROD_W'(gain_ff);
      step_raw   = step_prod[PROD_W-1:3];
      thr_prod   = THRP_W'(win_ff) * THRP_W'(beta_ff);
      thr_raw    = thr_prod[THRP_W-1:BETA_W];
      thr_val    = (thr_raw < WINDOW_WIDTH'(2)) ? WINDOW_WIDTH'(2) : thr_raw;
      thr_ext    = DIV_W'(thr_val);
      win_ext    = EST_W'(win_ff);
      win100     = 64'(win_ff) * 64'd100;
      q_clamped  = (div_rsp.quotient < DIV_W'(2)) ? DIV_W'(2) : div_rsp.quotient;
      idle_ticks = now_ff - lsend_ff;
      since_epoch = now_ff - epoch_ff;
   end

   assign req_stall = reset || (state_ff != S_IDLE);
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      state_in     = state_ff;
      beta_in      = beta_ff;
      gain_in      = gain_ff;
      hold_in      = hold_ff;
      inc_in       = inc_ff;
      prev_max_in  = prev_max_ff;
      prev_win_in  = prev_win_ff;
      prev_time_in = prev_time_ff;
      epoch_in     = epoch_ff;
      acc_in       = acc_ff;
      est_in       = est_ff;
      tx_flag_in   = tx_flag_ff;
      op_in        = op_ff;
      now_in       = now_ff;
      win_in       = win_ff;
      acked_in     = acked_ff;
      lsend_in     = lsend_ff;
      step_in      = step_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_thr_in   = rsp_thr_ff;

      div_req            = '0;
      div_req.iterations = DIV_ITER_W'(DIV_W);

      if (cfg_write) begin
         case (csr_paddr[3:2])
            CSR_BACKOFF: beta_in = csr_pwdata[BETA_W-1:0];
            CSR_GAIN:    gain_in = csr_pwdata[GAIN_W-1:0];
            CSR_HOLD:    hold_in = csr_pwdata[HOLD_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               now_in   = req_now_ticks;
               win_in   = req_window;
               acked_in = req_acked_count;
               lsend_in = req_last_send_ticks;
               case (req_opcode)
                  OP_ACK:      state_in = S_ACK;
                  OP_LOSS_REQ: state_in = S_LOSS;
                  OP_TX_START: state_in = S_TX1;
                  default:     state_in = S_CLEAR;
               endcase
            end
         end
         S_ACK: begin
            if (hold_skip) begin
               acc_in   = acc_sum;
               state_in = S_OUT;
            end else begin
               prev_win_in  = win_ff;
               prev_time_in = now_ff;
               if (epoch_ff == '0) begin
                  epoch_in = now_ff;
                  acc_in   = ACC_W'(acked_ff);
                  est_in   = win_ext;
               end else begin
                  acc_in = acc_sum;
               end
               step_in  = (step_raw == '0) ? STEP_W'(1) : step_raw;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            // n = (acc - 1) / step, acc leaves as remainder + 1
            if (CMP_W'(acc_ff) > CMP_W'(step_ff)) begin
               div_req.start      = 1'b1;
               div_req.iterations = DIV_ITER_W'(DIV_W);
               div_req.dividend   = acc_ff - 1'b1;
               div_req.divisor    = DIV_W'(step_ff);
               state_in           = S_DIV1;
            end else begin
               state_in = S_EST;
            end
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               acc_in   = ACC_W'(div_rsp.remainder) + ACC_W'(1);
               est_in   = est_ff + EST_W'(div_rsp.quotient);
               state_in = S_EST;
            end
         end
         S_EST: begin
            if (est_ff > win_ext) begin
               div_req.start      = 1'b1;
               div_req.iterations = DIV_ITER_W'(WINDOW_WIDTH);
               div_req.dividend   = DIV_W'(win_ff) << (DIV_W - WINDOW_WIDTH);
               div_req.divisor    = DIV_W'(est_ff - win_ext);
               state_in           = S_DIV2;
            end else begin
               inc_in   = win100[CNT_W-1:0];
               state_in = S_OUT;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               inc_in   = q_clamped[CNT_W-1:0];
               state_in = S_OUT;
            end
         end
         S_LOSS: begin
            epoch_in    = '0;
            prev_max_in = win_ff;
            thr_in      = thr_ext[THR_W-1:0];
            state_in    = S_OUT;
         end
         S_TX1: begin
            tx_flag_in = 1'b0;
            if ((epoch_ff != '0) && (idle_ticks != '0) && !idle_ticks[TIME_W-1]) begin
               epoch_in   = epoch_ff + idle_ticks;
               tx_flag_in = 1'b1;
            end
            state_in = S_TX2;
         end
         S_TX2: begin
            if (tx_flag_ff && since_epoch[TIME_W-1]) begin
               epoch_in = now_ff;
            end
            state_in = S_OUT;
         end
         S_CLEAR: begin
            inc_in       = '0;
            prev_max_in  = '0;
            prev_win_in  = '0;
            prev_time_in = '0;
            epoch_in     = '0;
            acc_in       = '0;
            est_in       = '0;
            state_in     = S_OUT;
         end
         S_OUT: begin
            // load the result beat once the output register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = (op_ff == OP_ACK) ? inc_ff : '0;
               rsp_thr_in   = (op_ff == OP_LOSS_REQ) ? thr_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         beta_ff      <= BETA_W'(717);
         gain_ff      <= GAIN_W'(15);
         hold_ff      <= HOLD_W'(31);
         inc_ff       <= '0;
         prev_max_ff  <= '0;
         prev_win_ff  <= '0;
         prev_time_ff <= '0;
         epoch_ff     <= '0;
         acc_ff       <= '0;
         est_ff       <= '0;
         tx_flag_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beta_ff      <= beta_in;
         gain_ff      <= gain_in;
         hold_ff      <= hold_in;
         inc_ff       <= inc_in;
         prev_max_ff  <= prev_max_in;
         prev_win_ff  <= prev_win_in;
         prev_time_ff <= prev_time_in;
         epoch_ff     <= epoch_in;
         acc_ff       <= acc_in;
         est_ff       <= est_in;
         tx_flag_ff   <= tx_flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      now_ff     <= now_in;
      win_ff     <= win_in;
      acked_ff   <= acked_in;
      lsend_ff   <= lsend_in;
      step_ff    <= step_in;
      thr_ff     <= thr_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_thr_ff <= rsp_thr_in;
   end

   // register readback
   always_comb begin
      case (csr_paddr[3:2])
         CSR_BACKOFF: csr_prdata = 32'(beta_ff);
         CSR_GAIN:    csr_prdata = 32'(gain_ff);
         CSR_HOLD:    csr_prdata = 32'(hold_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign csr_pready               = 1'b1;
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_acks_per_increment   = rsp_cnt_ff;
   assign rsp_slow_start_threshold = rsp_thr_ff;

   // divider is only launched from the two launch steps of an ack
   a_div_launch: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (state_ff == S_CHK || state_ff == S_EST))
      else $error("divider started outside an ack launch step");

   // while waiting on the divider it must be running or just finished
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV1 || state_ff == S_DIV2) |-> (div_rsp.busy || div_rsp.done))
      else $error("sequencer waits on an idle divider");

   // a free output register always takes the result and the sequencer returns to idle
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !(rsp_valid_ff && rsp_stall)) |=>
      (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result beat not loaded");

   // loss state leaves the flow state cleared before its result goes out
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && op_ff == OP_LOSS_STATE) |->
      (epoch_ff == '0 && acc_ff == '0 && est_ff == '0 && inc_ff == '0))
      else $error("loss state did not clear flow state");

endmodule

`default_nettype wire

[src/rfcg_div.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
// dividend is MSB-aligned by the caller when fewer than DIV_W iterations run
module rfcg_div (
   input  wire                  clock,
   input  wire                  reset,
   input  rfcg_pkg::div_req_type div_req,
   output rfcg_pkg::div_rsp_type div_rsp
);
   import rfcg_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_ITER_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [DIV_W-1:0]      dvs_ff, dvs_in;

   logic [DIV_W:0] trial;
   logic [DIV_W:0] diff;
   logic           fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.iterations;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire
